### sv/rrc_pkg.sv
package rrc_pkg;

  localparam int MAX_ATTRS_DEF = 32;

  // largest position count attr_count can ask for
  localparam int CNT_LIMIT = 63;

  localparam logic [7:0] BYTE_NL  = 8'h0A;
  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_BS  = 8'h5C;

  localparam logic [1:0] MODE_DATA = 2'd0;
  localparam logic [1:0] MODE_END  = 2'd1;
  localparam logic [1:0] MODE_DESC = 2'd2;

  localparam logic CFG_ATTR_COUNT = 1'b0;
  localparam logic CFG_MAX_SIZE   = 1'b1;

  localparam logic [5:0]  ATTR_COUNT_RST = 6'd1;
  localparam logic [15:0] MAX_SIZE_RST   = 16'd4096;

  localparam int DESC_W   = 17;
  localparam int FIXED_BIT = 16;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_DESC = 2'd2,
    KIND_NOP  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_BETWEEN = 3'd0,
    PH_START   = 3'd1,
    PH_TERM    = 3'd2,
    PH_ESC     = 3'd3,
    PH_FIXED   = 3'd4,
    PH_FINAL   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DONE      = 3'd1,
    ST_NEWLINE   = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_PREMATURE = 3'd4,
    ST_NO_NL     = 3'd5,
    ST_CLEAN_END = 3'd6
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        is_nl;
    logic        is_nul;
    logic        is_bs;
    logic [4:0]  desc_index;
    logic        desc_fixed;
    logic [15:0] desc_value;
  } item_t;

endpackage

### sv/rrc_front.sv
module rrc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [31:0]    in_tdata,
  input  logic [1:0]     in_tuser,
  output rrc_pkg::item_t q_item,
  output logic           q_valid,
  input  logic           q_pop
);
  import rrc_pkg::*;

  item_t       q_mem_r [QDEPTH];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        push;
  item_t       cls;

  // decode the word once so the back end compares single flags
  always_comb begin
    cls.data_byte  = in_tdata[7:0];
    cls.desc_index = in_tdata[12:8];
    cls.desc_fixed = in_tdata[13];
    cls.desc_value = in_tdata[29:14];
    cls.is_nl      = (in_tdata[7:0] == BYTE_NL);
    cls.is_nul     = (in_tdata[7:0] == BYTE_NUL);
    cls.is_bs      = (in_tdata[7:0] == BYTE_BS);
    case (in_tuser)
      MODE_DATA: cls.kind = KIND_BYTE;
      MODE_END:  cls.kind = KIND_END;
      MODE_DESC: cls.kind = KIND_DESC;
      default:   cls.kind = KIND_NOP;
    endcase
  end

  assign in_tready = (cnt_r != 2'(QDEPTH));
  assign push      = in_tvalid & in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### sv/rrc_back.sv
module rrc_back #(
  parameter int MAX_ATTRS = rrc_pkg::MAX_ATTRS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rrc_pkg::item_t q_item,
  input  logic           q_valid,
  output logic           q_pop,
  input  logic           cfg_we,
  input  logic           cfg_sel,
  input  logic [15:0]    cfg_wdata,
  output logic           out_valid,
  input  logic           out_take,
  output logic [2:0]     out_status,
  output logic [31:0]    out_count,
  output logic [4:0]     out_pos,
  output logic           out_warn
);
  import rrc_pkg::*;

  // only slots reachable by a 5-bit index are stored
  localparam int TD      = (MAX_ATTRS < 32) ? MAX_ATTRS : 32;
  localparam int TAW     = (TD > 1) ? $clog2(TD) : 1;
  localparam int CNT_MAX = (MAX_ATTRS < CNT_LIMIT) ? MAX_ATTRS : CNT_LIMIT;
  localparam int AW      = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

  logic [DESC_W-1:0] desc_r [TD];
  logic [TD-1:0]     zmask_r;

  logic [5:0]        attr_count_r;
  logic [15:0]       max_size_r;

  logic [31:0]       tuples_r,    tuples_nxt;
  logic [AW-1:0]     cur_r,       cur_nxt;
  phase_t            phase_r,     phase_nxt;
  logic [15:0]       bytes_r,     bytes_nxt;
  logic              nul_r,       nul_nxt;
  logic              warned_r,    warned_nxt;
  status_t           err_r,       err_nxt;
  logic [DESC_W-1:0] cur_desc_r,  cur_desc_nxt;

  logic              out_valid_r;
  status_t           out_status_r, status_nxt;
  logic [31:0]       out_count_r;
  logic [4:0]        out_pos_r;
  logic              out_warn_r,   warn_nxt;

  logic [5:0]        n_eff;
  logic [AW-1:0]     last;
  logic [AW-1:0]     start;
  logic [AW-1:0]     ff;
  logic [AW-1:0]     rd_pos;
  logic [DESC_W-1:0] rd_desc;
  logic              desc_we;
  logic              idx_ok;

  assign q_pop = q_valid & (~out_valid_r | out_take);

  always_comb begin
    if (attr_count_r == 6'd0) begin
      n_eff = 6'd1;
    end else if (attr_count_r > 6'(CNT_MAX)) begin
      n_eff = 6'(CNT_MAX);
    end else begin
      n_eff = attr_count_r;
    end
    last = AW'(n_eff - 6'd1);
  end

  // First attribute from start on that takes bytes; zero-width fixed slots are
  // passed over, the last attribute always stops the search.
  always_comb begin
    if (phase_r == PH_BETWEEN) begin
      start = '0;
    end else if (cur_r > last) begin
      start = last;
    end else begin
      start = cur_r;
    end
    ff = last;
    for (int i = CNT_MAX - 1; i >= 0; i--) begin
      if ((!zmask_r[TAW'(i)] || AW'(i) == last || max_size_r == 16'd0) &&
          AW'(i) >= start) begin
        ff = AW'(i);
      end
    end
    // on the entry byte the last-slot check only fires when ff is the last slot
    if (phase_r == PH_BETWEEN || phase_r == PH_START) begin
      rd_pos = ff;
    end else begin
      rd_pos = last;
    end
    rd_desc = desc_r[TAW'(rd_pos)];
  end

  assign idx_ok = (6'(q_item.desc_index) < 6'(TD));

  always_comb begin
    logic       do_term;
    logic       fin;
    logic [7:0] term;
    tuples_nxt   = tuples_r;
    cur_nxt      = cur_r;
    phase_nxt    = phase_r;
    bytes_nxt    = bytes_r;
    nul_nxt      = nul_r;
    warned_nxt   = warned_r;
    err_nxt      = err_r;
    cur_desc_nxt = cur_desc_r;
    status_nxt   = ST_OK;
    warn_nxt     = 1'b0;
    desc_we      = 1'b0;
    do_term      = 1'b0;
    fin          = 1'b0;
    term         = '0;
    case (q_item.kind)
      KIND_DESC: begin
        desc_we = idx_ok;
        if (idx_ok && TAW'(q_item.desc_index) == TAW'(cur_r)) begin
          cur_desc_nxt = {q_item.desc_fixed, q_item.desc_value};
        end
        status_nxt = err_r;
      end
      KIND_END: begin
        if (err_r != ST_OK) begin
          status_nxt = err_r;
        end else if (phase_r == PH_BETWEEN) begin
          status_nxt = ST_CLEAN_END;
        end else if (phase_r == PH_FINAL) begin
          err_nxt    = ST_NO_NL;
          status_nxt = ST_NO_NL;
        end else begin
          err_nxt    = ST_PREMATURE;
          status_nxt = ST_PREMATURE;
        end
      end
      KIND_BYTE: begin
        if (err_r != ST_OK) begin
          status_nxt = err_r;
        end else begin
          if (phase_nxt == PH_BETWEEN) begin
            tuples_nxt = tuples_r + 32'd1;
            cur_nxt    = '0;
            phase_nxt  = PH_START;
          end
          if (phase_nxt == PH_START) begin
            cur_nxt      = ff;
            cur_desc_nxt = rd_desc;
            if (rd_desc[FIXED_BIT]) begin
              if (rd_desc[15:0] >= max_size_r) begin
                err_nxt = ST_TOO_LONG;
              end else if (rd_desc[15:0] == 16'd0) begin
                phase_nxt = PH_FINAL;
              end else begin
                phase_nxt = PH_FIXED;
                bytes_nxt = '0;
                nul_nxt   = 1'b0;
              end
            end else begin
              phase_nxt = PH_TERM;
              bytes_nxt = '0;
            end
          end
          term = cur_desc_nxt[7:0];
          if (err_nxt == ST_OK) begin
            case (phase_nxt)
              PH_TERM: do_term = 1'b1;
              PH_ESC: begin
                if (q_item.data_byte == term && !q_item.is_nl && !q_item.is_nul) begin
                  if (bytes_nxt >= max_size_r) begin
                    err_nxt = ST_TOO_LONG;
                  end else begin
                    bytes_nxt = bytes_nxt + 16'd1;
                    phase_nxt = PH_TERM;
                  end
                end else begin
                  phase_nxt = PH_TERM;
                  do_term   = 1'b1;
                end
              end
              PH_FIXED: begin
                if (q_item.is_nl && !nul_nxt) begin
                  if (!warned_r) begin
                    warned_nxt = 1'b1;
                    warn_nxt   = 1'b1;
                  end
                end else if (q_item.is_nul) begin
                  nul_nxt = 1'b1;
                end
                bytes_nxt = bytes_nxt + 16'd1;
                fin       = (bytes_nxt >= cur_desc_nxt[15:0]);
              end
              PH_FINAL: begin
                if (q_item.is_nl) begin
                  phase_nxt  = PH_BETWEEN;
                  status_nxt = ST_DONE;
                end else begin
                  err_nxt = ST_NO_NL;
                end
              end
              default: phase_nxt = PH_BETWEEN;
            endcase
            if (do_term) begin
              if (q_item.data_byte == term || q_item.is_bs || !q_item.is_nl) begin
                if (bytes_nxt >= max_size_r) begin
                  err_nxt = ST_TOO_LONG;
                end else begin
                  bytes_nxt = bytes_nxt + 16'd1;
                  if (q_item.data_byte == term) begin
                    fin = 1'b1;
                  end else if (q_item.is_bs) begin
                    phase_nxt = PH_ESC;
                  end
                end
              end else begin
                err_nxt = ST_NEWLINE;
              end
            end
            if (fin) begin
              if (cur_nxt >= last) begin
                cur_nxt = last;
                if (rd_desc[FIXED_BIT]) begin
                  phase_nxt = PH_FINAL;
                end else begin
                  phase_nxt  = PH_BETWEEN;
                  status_nxt = ST_DONE;
                end
              end else begin
                cur_nxt   = cur_nxt + AW'(1);
                phase_nxt = PH_START;
              end
            end
          end
          if (err_nxt != ST_OK) begin
            status_nxt = err_nxt;
          end
        end
      end
      default: status_nxt = err_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && desc_we) begin
      desc_r[TAW'(q_item.desc_index)]  <= {q_item.desc_fixed, q_item.desc_value};
      zmask_r[TAW'(q_item.desc_index)] <= q_item.desc_fixed & (q_item.desc_value == 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_desc_r   <= cur_desc_nxt;
      out_status_r <= status_nxt;
      out_count_r  <= tuples_nxt;
      out_pos_r    <= 5'(cur_nxt);
      out_warn_r   <= warn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_count_r <= ATTR_COUNT_RST;
      max_size_r   <= MAX_SIZE_RST;
      tuples_r     <= '0;
      cur_r        <= '0;
      phase_r      <= PH_BETWEEN;
      bytes_r      <= '0;
      nul_r        <= 1'b0;
      warned_r     <= 1'b0;
      err_r        <= ST_OK;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_sel)
          CFG_ATTR_COUNT: attr_count_r <= cfg_wdata[5:0];
          CFG_MAX_SIZE:   max_size_r   <= cfg_wdata;
          default:        max_size_r   <= max_size_r;
        endcase
      end
      if (q_pop) begin
        tuples_r <= tuples_nxt;
        cur_r    <= cur_nxt;
        phase_r  <= phase_nxt;
        bytes_r  <= bytes_nxt;
        nul_r    <= nul_nxt;
        warned_r <= warned_nxt;
        err_r    <= err_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;
  assign out_pos    = out_pos_r;
  assign out_warn   = out_warn_r;

endmodule

### sv/relation_record_checker.sv
// Checks a byte stream of flat-file tuples against a per-attribute descriptor
// table, one word per cycle unless a low out_tready holds the output.
// in_*  : input words. in_tuser selects data byte, end of input or
//         descriptor write; every accepted word yields exactly one out word.
// out_* : status, running tuple count, attribute position and the one-off
//         newline warning. Errors latch: once set, every later word reports
//         the same status until reset.
// cfg_* : register writes (attr_count, max_attr_size), always ready; write
//         them only while no word is in flight.
// Throughput: one word per cycle while the output is taken; the back-end state
// update, including the zero-width skip search, is combinational.
// A two-word queue sits between front and back; when out_tready is low the
// output register holds, the queue fills and in_tready drops once it holds
// two words.
// Reset: counters, position and error cleared, attr_count 1, max_attr_size
// 4096. Descriptors are undefined until written.
module relation_record_checker #(
  parameter int MAX_ATTRS = rrc_pkg::MAX_ATTRS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // data_byte[7:0], desc_index[12:8], desc_fixed[13],
                                  // desc_value[29:14], zero[31:30]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // tuple_count[31:0], attr_position[36:32],
                                  // nl_warning[37], zero[39:38]
  output logic [2:0]  out_tuser,  // status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import rrc_pkg::*;

  item_t       q_item;
  logic        q_valid;
  logic        q_pop;
  logic [31:0] count;
  logic [4:0]  pos;
  logic        warn;

  assign cfg_ready = 1'b1;

  rrc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop)
  );

  rrc_back #(
    .MAX_ATTRS (MAX_ATTRS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_sel    (cfg_index),
    .cfg_wdata  (cfg_data),
    .out_valid  (out_tvalid),
    .out_take   (out_tready),
    .out_status (out_tuser),
    .out_count  (count),
    .out_pos    (pos),
    .out_warn   (warn)
  );

  assign out_tdata = {2'b00, warn, pos, count};

endmodule
